/* design/bsds_pkg.sv */
// ----------------------------------------------------------------------------
// Byte sample diversity scorer package
// Shared widths, codes and the word types passed between the block's parts.
// ----------------------------------------------------------------------------
package bsds_pkg;

   localparam int ADDR_W  = 48;
   localparam int SCORE_W = 12;
   localparam int DIST_W  = 9;
   localparam int RUN_W   = 8;
   localparam int BYTE_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Weighting of the distinct count is a multiply by 16, done as a shift.
   localparam int WEIGHT_SHIFT = 4;
   localparam int WEIGHTED_W   = DIST_W + WEIGHT_SHIFT;
   localparam logic [RUN_W-1:0] RUN_MAX = '1;

   // Queue depths on either side of the scoring pipeline.
   localparam int REQ_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // Command codes on the request side.
   localparam logic CMD_BYTE   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // Result kinds on the response side.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RUN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [RUN_W-1:0]   MAX_RUN_RESET   = 8'd8;
   localparam logic [DIST_W-1:0]  MIN_DIST_RESET  = 9'd8;
   localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 12'd120;

   typedef struct packed {
      logic                 is_finish;
      logic [BYTE_W-1:0]    data_byte;
      logic [ADDR_W-1:0]    sample_address;
   } req_word_type;

   typedef struct packed {
      logic                 result_kind;
      logic [SCORE_W-1:0]   score;
      logic [ADDR_W-1:0]    best_address;
      logic                 found;
   } rsp_word_type;

   typedef struct packed {
      logic [RUN_W-1:0]     max_run_allowed;
      logic [DIST_W-1:0]    min_distinct;
      logic [SCORE_W-1:0]   accept_threshold;
   } cfg_type;

endpackage

/* design/bsds_front.sv */
// ----------------------------------------------------------------------------
// Request queue
// Takes request words, decodes the command and holds them for the back end.
// ----------------------------------------------------------------------------
module bsds_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic                   command,
   input  logic [7:0]             data_byte,
   input  logic [47:0]            sample_address,
   output logic                   empty,
   input  logic                   pop,
   output bsds_pkg::req_word_type word
);
   import bsds_pkg::*;

   localparam int PTR_W = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(REQ_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(REQ_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(REQ_DEPTH);

   req_word_type     store_ff [REQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;
   req_word_type     incoming;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign word    = store_ff[rd_ptr_ff];

   always_comb begin
      incoming.is_finish      = (command == CMD_FINISH);
      incoming.data_byte      = data_byte;
      incoming.sample_address = sample_address;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

/* design/bsds_back.sv */
// ----------------------------------------------------------------------------
// Sample statistics and scoring
// Stage one folds bytes into the seen map and run counters; stage two scores
// finished samples, tracks the best one and builds finish reports.
// ----------------------------------------------------------------------------
module bsds_back #(
   parameter int SAMPLE_BYTES = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bsds_pkg::cfg_type      cfg,
   input  logic                   req_empty,
   output logic                   req_pop,
   input  bsds_pkg::req_word_type req_word,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output bsds_pkg::rsp_word_type rsp_word
);
   import bsds_pkg::*;

   localparam logic [RUN_W-1:0] LAST_POS = RUN_W'(SAMPLE_BYTES - 1);

   // Stage one state.
   logic [255:0]        seen_ff, seen_in;
   logic [DIST_W-1:0]   distinct_ff, distinct_in;
   logic [RUN_W-1:0]    run_ff, run_in;
   logic [RUN_W-1:0]    longest_ff, longest_in;
   logic [BYTE_W-1:0]   prev_ff, prev_in;
   logic [RUN_W-1:0]    pos_ff, pos_in;
   logic [ADDR_W-1:0]   cur_addr_ff, cur_addr_in;

   // Stage two holding register.
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_finish_ff, s2_finish_in;
   logic [DIST_W-1:0]   s2_distinct_ff, s2_distinct_in;
   logic [RUN_W-1:0]    s2_longest_ff, s2_longest_in;
   logic [ADDR_W-1:0]   s2_addr_ff, s2_addr_in;

   logic [SCORE_W-1:0]  best_score_ff, best_score_in;
   logic [ADDR_W-1:0]   best_addr_ff, best_addr_in;

   logic                s2_ready, advance, last_byte, clear_sample;
   logic [RUN_W-1:0]    run_step;
   logic [DIST_W-1:0]   distinct_step;
   logic [RUN_W-1:0]    longest_step;
   logic [WEIGHTED_W-1:0] weighted;
   logic                fail;
   logic [SCORE_W-1:0]  score;
   logic                better;

   assign s2_ready = !s2_valid_ff || !rsp_full;
   assign advance  = !req_empty && s2_ready;
   assign req_pop  = advance;

   // Stage one: per-byte update of the sample statistics.
   always_comb begin
      last_byte    = !req_word.is_finish && (pos_ff == LAST_POS);
      clear_sample = advance && (req_word.is_finish || last_byte);

      run_step     = 8'd1;
      longest_step = longest_ff;
      if (pos_ff != '0 && req_word.data_byte == prev_ff) begin
         run_step     = (run_ff < RUN_MAX) ? run_ff + 1'b1 : run_ff;
         longest_step = (run_step > longest_ff) ? run_step : longest_ff;
      end
      distinct_step = seen_ff[req_word.data_byte] ? distinct_ff : distinct_ff + 1'b1;

      seen_in     = seen_ff;
      distinct_in = distinct_ff;
      run_in      = run_ff;
      longest_in  = longest_ff;
      prev_in     = prev_ff;
      pos_in      = pos_ff;
      cur_addr_in = cur_addr_ff;
      if (clear_sample) begin
         seen_in     = '0;
         distinct_in = '0;
         run_in      = 8'd1;
         longest_in  = 8'd1;
         prev_in     = '0;
         pos_in      = '0;
      end else if (advance) begin
         for (int i = 0; i < 256; i++) begin
            if (req_word.data_byte == BYTE_W'(i)) begin
               seen_in[i] = 1'b1;
            end
         end
         distinct_in = distinct_step;
         run_in      = run_step;
         longest_in  = longest_step;
         prev_in     = req_word.data_byte;
         pos_in      = pos_ff + 1'b1;
         if (pos_ff == '0) begin
            cur_addr_in = req_word.sample_address;
         end
      end

      // Hand a completed sample or a finish command to stage two.
      s2_valid_in    = s2_valid_ff && rsp_full;
      s2_finish_in   = s2_finish_ff;
      s2_distinct_in = s2_distinct_ff;
      s2_longest_in  = s2_longest_ff;
      s2_addr_in     = s2_addr_ff;
      if (advance && (req_word.is_finish || last_byte)) begin
         s2_valid_in    = 1'b1;
         s2_finish_in   = req_word.is_finish;
         s2_distinct_in = distinct_step;
         s2_longest_in  = longest_step;
         s2_addr_in     = cur_addr_ff;
      end
   end

   // Stage two: score, best tracking and the result word.
   always_comb begin
      weighted = {s2_distinct_ff, {WEIGHT_SHIFT{1'b0}}};
      fail = (s2_longest_ff > cfg.max_run_allowed) ||
             (s2_distinct_ff < cfg.min_distinct) ||
             (weighted < WEIGHTED_W'(s2_longest_ff));
      score  = fail ? '0 : SCORE_W'(weighted - WEIGHTED_W'(s2_longest_ff));
      better = score > best_score_ff;

      rsp_push      = s2_valid_ff && !rsp_full;
      best_score_in = best_score_ff;
      best_addr_in  = best_addr_ff;
      if (s2_finish_ff) begin
         rsp_word.result_kind  = KIND_FINISH;
         rsp_word.score        = best_score_ff;
         rsp_word.best_address = best_addr_ff;
         rsp_word.found        = (best_score_ff != '0) &&
                                 (best_score_ff >= cfg.accept_threshold);
         if (rsp_push) begin
            best_score_in = '0;
            best_addr_in  = '0;
         end
      end else begin
         rsp_word.result_kind  = KIND_SAMPLE;
         rsp_word.score        = score;
         rsp_word.best_address = s2_addr_ff;
         rsp_word.found        = better;
         if (rsp_push && better) begin
            best_score_in = score;
            best_addr_in  = s2_addr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= '0;
         distinct_ff   <= '0;
         run_ff        <= 8'd1;
         longest_ff    <= 8'd1;
         prev_ff       <= '0;
         pos_ff        <= '0;
         cur_addr_ff   <= '0;
         s2_valid_ff   <= 1'b0;
         best_score_ff <= '0;
         best_addr_ff  <= '0;
      end else begin
         seen_ff       <= seen_in;
         distinct_ff   <= distinct_in;
         run_ff        <= run_in;
         longest_ff    <= longest_in;
         prev_ff       <= prev_in;
         pos_ff        <= pos_in;
         cur_addr_ff   <= cur_addr_in;
         s2_valid_ff   <= s2_valid_in;
         best_score_ff <= best_score_in;
         best_addr_ff  <= best_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_finish_ff   <= s2_finish_in;
      s2_distinct_ff <= s2_distinct_in;
      s2_longest_ff  <= s2_longest_in;
      s2_addr_ff     <= s2_addr_in;
   end

endmodule

/* design/bsds_rsp_queue.sv */
// ----------------------------------------------------------------------------
// Response queue
// Holds scored words until the consumer pops them.
// ----------------------------------------------------------------------------
module bsds_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  bsds_pkg::rsp_word_type wr_word,
   output logic                   empty,
   input  logic                   pop,
   output bsds_pkg::rsp_word_type rd_word
);
   import bsds_pkg::*;

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RSP_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RSP_DEPTH);

   rsp_word_type     store_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_word = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

/* design/byte_sample_diversity_scorer.sv */
// ----------------------------------------------------------------------------
// Byte sample diversity scorer
// Scores fixed-length byte samples by distinct values and longest equal run,
// keeps the first best sample and reports it on a finish command.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Word
// req_      in         push / full           command, data_byte, sample_address
// rsp_      out        pop / empty           result_kind, score, best_address, found
// csr_      in         write_enable          index, write_data (no read-back)
//
// One word is taken per cycle while the request queue is not full. A byte word
// passes the request queue and the statistics stage, and the last byte of a
// sample or a finish word then passes the scoring stage register before its
// result enters the response queue, from which it can be popped.
// Throughput is one word per cycle while the response queue does not back up.
// Reset is synchronous and clears the seen map, counters, best sample and
// both queues at once, and loads the register reset values. When the
// response queue fills, the scoring stage and then the request queue back up.
//
module byte_sample_diversity_scorer #(
   parameter int SAMPLE_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   input  logic [47:0] req_sample_address,
   // Response channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_result_kind,
   output logic [11:0] rsp_score,
   output logic [47:0] rsp_best_address,
   output logic        rsp_found,
   // Configuration port
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_write_data
);
   import bsds_pkg::*;

   // Configuration registers. The user must change them only while the block is idle,
   // which the block does not enforce; the scoring stage reads them directly.
   cfg_type      cfg_ff, cfg_in;

   // Request queue to back end.
   logic         front_empty;
   logic         front_pop;
   req_word_type front_word;

   // Back end to response queue.
   logic         back_push;
   logic         back_full;
   rsp_word_type back_word;
   rsp_word_type out_word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_RUN:   cfg_in.max_run_allowed  = csr_write_data[RUN_W-1:0];
            CSR_MIN_DIST:  cfg_in.min_distinct     = csr_write_data[DIST_W-1:0];
            CSR_THRESHOLD: cfg_in.accept_threshold = csr_write_data[SCORE_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_run_allowed  <= MAX_RUN_RESET;
         cfg_ff.min_distinct     <= MIN_DIST_RESET;
         cfg_ff.accept_threshold <= THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: request queue and command decode.
   bsds_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (req_push),
      .full           (req_full),
      .command        (req_command),
      .data_byte      (req_data_byte),
      .sample_address (req_sample_address),
      .empty          (front_empty),
      .pop            (front_pop),
      .word           (front_word)
   );

   // Back end: sample statistics, scoring and best tracking.
   bsds_back #(
      .SAMPLE_BYTES (SAMPLE_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_empty (front_empty),
      .req_pop   (front_pop),
      .req_word  (front_word),
      .rsp_full  (back_full),
      .rsp_push  (back_push),
      .rsp_word  (back_word)
   );

   // Response queue toward the consumer.
   bsds_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (back_push),
      .full    (back_full),
      .wr_word (back_word),
      .empty   (rsp_empty),
      .pop     (rsp_pop),
      .rd_word (out_word)
   );

   assign rsp_result_kind  = out_word.result_kind;
   assign rsp_score        = out_word.score;
   assign rsp_best_address = out_word.best_address;
   assign rsp_found        = out_word.found;

endmodule
